// ----- hw/rtl/signed_coeff_bit_packer_macros.svh -----
// assertion helpers, clocked on clk_i and held off while rst_ni is low
`ifndef SIGNED_COEFF_BIT_PACKER_MACROS_SVH
`define SIGNED_COEFF_BIT_PACKER_MACROS_SVH

// same-cycle implication
`define SCBP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SCBP_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/scbp_pkg.sv -----
package scbp_pkg;

  localparam int LIMB_WIDTH_DEFAULT = 64;

  localparam int COEFF_W    = 64;
  localparam int FIELD_W    = 63;
  localparam int CB_W       = 6;
  localparam int BS_W       = 13;
  localparam int OL_W       = 6;
  localparam int LW_CNT_W   = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CB_W-1:0] COEFF_BITS_RESET  = 6'd16;
  localparam logic [BS_W-1:0] BUNDLE_SIZE_RESET = 13'd4;
  localparam logic [OL_W-1:0] OUT_LIMBS_RESET   = 6'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEFF_BITS  = 2'd0,
    CFG_BUNDLE_SIZE = 2'd1,
    CFG_OUT_LIMBS   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CHUNK,
    OP_FINISH,
    OP_PART,
    OP_DROP,
    OP_FILL,
    OP_HELD
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic lw_lt_ol;
    logic lw_le_ol;
    logic slot_free;
    logic bundle_end;
  } status_t;

endpackage

// ----- hw/rtl/scbp_ifs.sv -----
interface scbp_coeff_if;
  import scbp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COEFF_W-1:0] coeff_value;
  logic                      last_coeff;
  modport source (output valid, coeff_value, last_coeff, input ready);
  modport sink (input valid, coeff_value, last_coeff, output ready);
endinterface

interface scbp_limb_if;
  logic        valid;
  logic        ready;
  logic [63:0] limb_word;
  logic        last_limb;
  logic        overflow;
  modport source (output valid, limb_word, last_limb, overflow, input ready);
  modport sink (input valid, limb_word, last_limb, overflow, output ready);
endinterface

interface scbp_cfg_if;
  import scbp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

// ----- hw/rtl/scbp_ctrl.sv -----
module scbp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  scbp_pkg::status_t st_i,
  output scbp_pkg::cmd_t    cmd_o
);
  import scbp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PACK,
    S_PART,
    S_FILL,
    S_HELD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = S_PACK;
        end
      end
      S_PACK: begin
        if (st_i.full) begin
          // a limb that leaves the block needs the output slot
          if (!st_i.lw_lt_ol || st_i.slot_free) begin
            cmd_o.op = OP_CHUNK;
          end
        end else begin
          cmd_o.op = OP_FINISH;
          state_d  = st_i.bundle_end ? S_PART : S_IDLE;
        end
      end
      S_PART: begin
        if (st_i.lw_lt_ol) begin
          if (st_i.slot_free) begin
            cmd_o.op = OP_PART;
            state_d  = S_FILL;
          end
        end else begin
          cmd_o.op = OP_DROP;
          state_d  = S_FILL;
        end
      end
      S_FILL: begin
        if (st_i.lw_le_ol) begin
          if (!st_i.lw_lt_ol || st_i.slot_free) begin
            cmd_o.op = OP_FILL;
          end
        end else begin
          state_d = S_HELD;
        end
      end
      S_HELD: begin
        if (st_i.slot_free) begin
          cmd_o.op = OP_HELD;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/scbp_datapath.sv -----
module scbp_datapath #(
  parameter int LIMB_WIDTH = scbp_pkg::LIMB_WIDTH_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  scbp_pkg::cmd_t                      cmd_i,
  output scbp_pkg::status_t                   st_o,
  input  logic signed [scbp_pkg::COEFF_W-1:0] coeff_value_i,
  input  logic                                last_coeff_i,
  input  logic                                cfg_we_i,
  input  logic [scbp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [scbp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [63:0]                         limb_word_o,
  output logic                                last_limb_o,
  output logic                                overflow_o
);
  import scbp_pkg::*;

  localparam int PCW = $clog2(LIMB_WIDTH);
  localparam int SHW = FIELD_W + LIMB_WIDTH;
  localparam logic [LW_CNT_W-1:0] LW_CONST = LW_CNT_W'(LIMB_WIDTH);

  // configuration
  logic [CB_W-1:0] cb_q;
  logic [BS_W-1:0] bs_q;
  logic [OL_W-1:0] ol_q;

  // block state
  logic [LIMB_WIDTH-1:0] pend_q, held_q;
  logic [PCW-1:0]        pc_q;
  logic                  borrow_q;
  logic [LW_CNT_W-1:0]   lw_q;
  logic [BS_W-1:0]       cib_q;
  logic                  ovf_q;

  // coefficient in flight
  logic [FIELD_W-1:0] field_q;
  logic [CB_W-1:0]    rem_q;
  logic               last_q;

  // output register
  logic                  out_valid_q;
  logic [LIMB_WIDTH-1:0] out_word_q;
  logic                  out_last_q, out_ovf_q;

  logic [CB_W-1:0]       bits_eff;
  logic [BS_W-1:0]       bs_eff;
  logic [COEFF_W-1:0]    diff, mask;
  logic [FIELD_W-1:0]    field_new, field_shr;
  logic                  neg;
  logic [LW_CNT_W-1:0]   sum_w, space;
  logic [SHW-1:0]        shifted;
  logic [LIMB_WIDTH-1:0] pack_limb, part_limb, ext_limb, put_val;
  logic [BS_W-1:0]       cib_inc;
  logic                  do_put, lw_lt_ol, lw_eq_ol;

  always_comb begin
    bits_eff  = (cb_q == '0) ? CB_W'(1) : cb_q;
    bs_eff    = (bs_q == '0) ? BS_W'(1) : bs_q;
    diff      = coeff_value_i - COEFF_W'(borrow_q);
    mask      = (COEFF_W'(1) << bits_eff) - COEFF_W'(1);
    field_new = diff[FIELD_W-1:0] & mask[FIELD_W-1:0];
    // exact difference is negative, including the minimum with borrow set
    neg       = coeff_value_i[COEFF_W-1] || ((coeff_value_i == '0) && borrow_q);

    sum_w     = LW_CNT_W'(pc_q) + LW_CNT_W'(rem_q);
    space     = LW_CONST - LW_CNT_W'(pc_q);
    shifted   = SHW'(field_q) << pc_q;
    pack_limb = pend_q | shifted[LIMB_WIDTH-1:0];
    field_shr = field_q >> space;
    part_limb = pend_q | (borrow_q ? ({LIMB_WIDTH{1'b1}} << pc_q) : '0);
    ext_limb  = {LIMB_WIDTH{borrow_q}};
    cib_inc   = cib_q + BS_W'(1);

    lw_lt_ol  = lw_q < LW_CNT_W'(ol_q);
    lw_eq_ol  = lw_q == LW_CNT_W'(ol_q);

    case (cmd_i.op)
      OP_CHUNK: put_val = pack_limb;
      OP_PART:  put_val = part_limb;
      default:  put_val = ext_limb;
    endcase
    do_put = (cmd_i.op == OP_CHUNK) || (cmd_i.op == OP_PART) || (cmd_i.op == OP_FILL);

    st_o.full       = sum_w >= LW_CONST;
    st_o.lw_lt_ol   = lw_lt_ol;
    st_o.lw_le_ol   = lw_lt_ol || lw_eq_ol;
    st_o.slot_free  = !out_valid_q || out_ready_i;
    st_o.bundle_end = last_q || (cib_inc >= bs_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cb_q <= COEFF_BITS_RESET;
      bs_q <= BUNDLE_SIZE_RESET;
      ol_q <= OUT_LIMBS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_COEFF_BITS:  cb_q <= cfg_data_i[CB_W-1:0];
        CFG_BUNDLE_SIZE: bs_q <= cfg_data_i[BS_W-1:0];
        CFG_OUT_LIMBS:   ol_q <= cfg_data_i[OL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      held_q      <= '0;
      pc_q        <= '0;
      borrow_q    <= 1'b0;
      lw_q        <= '0;
      cib_q       <= '0;
      ovf_q       <= 1'b0;
      field_q     <= '0;
      rem_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((do_put && lw_lt_ol) || (cmd_i.op == OP_HELD)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (do_put) begin
        if (lw_lt_ol) begin
          lw_q <= lw_q + LW_CNT_W'(1);
        end else if (lw_eq_ol) begin
          held_q <= put_val;
          lw_q   <= lw_q + LW_CNT_W'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      case (cmd_i.op)
        OP_ACCEPT: begin
          field_q  <= field_new;
          rem_q    <= bits_eff;
          last_q   <= last_coeff_i;
          borrow_q <= neg;
        end
        OP_CHUNK: begin
          field_q <= field_shr;
          rem_q   <= rem_q - space[CB_W-1:0];
          pend_q  <= '0;
          pc_q    <= '0;
        end
        OP_FINISH: begin
          pend_q <= pack_limb;
          pc_q   <= sum_w[PCW-1:0];
          cib_q  <= cib_inc;
        end
        OP_DROP: begin
          if (pc_q != '0) begin
            ovf_q <= 1'b1;
          end
        end
        OP_HELD: begin
          pend_q   <= '0;
          held_q   <= '0;
          pc_q     <= '0;
          borrow_q <= 1'b0;
          lw_q     <= '0;
          cib_q    <= '0;
          ovf_q    <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_put && lw_lt_ol) begin
      out_word_q <= put_val;
      out_last_q <= 1'b0;
      out_ovf_q  <= ovf_q;
    end else if (cmd_i.op == OP_HELD) begin
      out_word_q <= held_q;
      out_last_q <= 1'b1;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign limb_word_o = 64'(out_word_q);
  assign last_limb_o = out_last_q;
  assign overflow_o  = out_ovf_q;

endmodule

// ----- hw/rtl/signed_coeff_bit_packer.sv -----
// sequence: a coefficient is accepted, a chunk step puts out each limb that it fills and
//   a finish step packs the rest; a bundle end adds a part step for the partial limb,
//   fill steps and the final held limb; a new coefficient is accepted only once the
//   previous one is packed; output stalls hold the limb sequencer
// reset: async active low; clears block state, output valid and the sequencer,
//   and loads coeff_bits 16, bundle_size 4, out_limbs 4
`include "signed_coeff_bit_packer_macros.svh"

module signed_coeff_bit_packer #(
  parameter int LIMB_WIDTH = scbp_pkg::LIMB_WIDTH_DEFAULT
) (
  input logic         clk_i,
  input logic         rst_ni,
  scbp_coeff_if.sink  coeff_i,
  scbp_limb_if.source limb_o,
  scbp_cfg_if.sink    cfg_i
);
  import scbp_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_i.ready = 1'b1;

  scbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (coeff_i.valid),
    .in_ready_o (coeff_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  scbp_datapath #(
    .LIMB_WIDTH (LIMB_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .coeff_value_i (coeff_i.coeff_value),
    .last_coeff_i  (coeff_i.last_coeff),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.wdata),
    .out_ready_i   (limb_o.ready),
    .out_valid_o   (limb_o.valid),
    .limb_word_o   (limb_o.limb_word),
    .last_limb_o   (limb_o.last_limb),
    .overflow_o    (limb_o.overflow)
  );

  `SCBP_ASSERT_NXT(a_busy_after_beat, coeff_i.valid && coeff_i.ready, !coeff_i.ready, "coefficient taken while previous one still packing")
  `SCBP_ASSERT_IMP(a_load_slot, (cmd.op == OP_HELD) || (cmd.op == OP_PART), st.slot_free, "output register loaded while occupied")
  `SCBP_ASSERT_NXT(a_held_last, cmd.op == OP_HELD, limb_o.valid && limb_o.last_limb, "final limb of block not offered")

endmodule
